/* rtl/sha1_digest_top_macros.svh */
// assertion macros used by the sha1 digest core
`ifndef SHA1_DIGEST_TOP_MACROS_SVH
`define SHA1_DIGEST_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define SHA1D_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define SHA1D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/sha1d_pkg.sv */
// types, constants and round helpers for the sha1 digest block
package sha1d_pkg;

  // input transfer payload
  typedef struct packed {
    logic [31:0] message_word;
    logic [2:0]  byte_count;
    logic        last_word;
  } in_t;

  // output transfer payload
  typedef struct packed {
    logic [31:0] digest_0;
    logic [31:0] digest_1;
    logic [31:0] digest_2;
    logic [31:0] digest_3;
    logic [31:0] digest_4;
  } out_t;

  // classified word as it travels through the queue
  typedef struct packed {
    logic [31:0] word;       // masked and padded when short
    logic [5:0]  add_bits;   // message bits this word adds
    logic        last;
    logic        need_mark;  // full last word: pad word still to come
  } entry_t;

  // back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK,
    ST_FILL,
    ST_LEN_LO,
    ST_COMPRESS,
    ST_UPDATE,
    ST_DONE
  } state_t;

  localparam logic [31:0] K0 = 32'h5a82_7999;
  localparam logic [31:0] K1 = 32'h6ed9_eba1;
  localparam logic [31:0] K2 = 32'h8f1b_bcdc;
  localparam logic [31:0] K3 = 32'hca62_c1d6;

  localparam logic [31:0] H0_INIT = 32'h6745_2301;
  localparam logic [31:0] H1_INIT = 32'hefcd_ab89;
  localparam logic [31:0] H2_INIT = 32'h98ba_dcfe;
  localparam logic [31:0] H3_INIT = 32'h1032_5476;
  localparam logic [31:0] H4_INIT = 32'hc3d2_e1f0;

  localparam logic [7:0]  PAD_BYTE   = 8'h80;
  localparam logic [31:0] PAD_WORD   = {PAD_BYTE, 24'h00_0000};
  localparam logic [3:0]  LEN_SLOT   = 4'd14;   // 448 bits into the block
  localparam logic [3:0]  LAST_SLOT  = 4'd15;
  localparam logic [6:0]  LAST_ROUND = 7'd79;
  localparam logic [5:0]  FULL_BITS  = 6'd32;

  // round-dependent boolean function
  function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (t < 7'd20) begin
      f = (b & c) ^ (~b & d);
    end else if (t < 7'd40) begin
      f = b ^ c ^ d;
    end else if (t < 7'd60) begin
      f = (b & c) ^ (b & d) ^ (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  // round-dependent additive constant
  function automatic logic [31:0] round_k(input logic [6:0] t);
    logic [31:0] k;
    if (t < 7'd20) begin
      k = K0;
    end else if (t < 7'd40) begin
      k = K1;
    end else if (t < 7'd60) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

endpackage

/* rtl/sha1d_front.sv */
// front end: saturates the count, masks and pads a short last word
module sha1d_front (
  input  sha1d_pkg::in_t    item,
  output sha1d_pkg::entry_t entry
);

  logic        short_word;
  logic [31:0] keep_mask;
  logic [31:0] pad_bits;

  // byte mask and pad position for a partial last word
  always_comb begin
    case (item.byte_count[1:0])
      2'd0: begin
        keep_mask = 32'h0000_0000;
        pad_bits  = {sha1d_pkg::PAD_BYTE, 24'h00_0000};
      end
      2'd1: begin
        keep_mask = 32'hff00_0000;
        pad_bits  = {8'h00, sha1d_pkg::PAD_BYTE, 16'h0000};
      end
      2'd2: begin
        keep_mask = 32'hffff_0000;
        pad_bits  = {16'h0000, sha1d_pkg::PAD_BYTE, 8'h00};
      end
      2'd3: begin
        keep_mask = 32'hffff_ff00;
        pad_bits  = {24'h00_0000, sha1d_pkg::PAD_BYTE};
      end
      default: begin
        keep_mask = 32'hffff_ffff;
        pad_bits  = 32'h0000_0000;
      end
    endcase
  end

  // counts of four and above, and every non-last word, are full words
  assign short_word = item.last_word && (item.byte_count < 3'd4);

  // classified queue entry
  always_comb begin
    entry.last      = item.last_word;
    entry.need_mark = item.last_word && !short_word;
    if (short_word) begin
      entry.word     = (item.message_word & keep_mask) | pad_bits;
      entry.add_bits = {1'b0, item.byte_count[1:0], 3'b000};
    end else begin
      entry.word     = item.message_word;
      entry.add_bits = sha1d_pkg::FULL_BITS;
    end
  end

endmodule

/* rtl/sha1d_fifo.sv */
// small queue of classified words between the front and back ends
module sha1d_fifo #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  sha1d_pkg::entry_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output sha1d_pkg::entry_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  sha1d_pkg::entry_t slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (fill != FULL_CNT);
  assign pop_valid  = (fill != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

/* rtl/sha1d_core.sv */
// back end: block assembly, padding, 80-round compression and digest output
`include "sha1_digest_top_macros.svh"

module sha1d_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  sha1d_pkg::entry_t pop_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sha1d_pkg::out_t   out_data
);

  sha1d_pkg::state_t state;
  sha1d_pkg::state_t state_next;
  sha1d_pkg::state_t resume;
  sha1d_pkg::state_t resume_next;
  sha1d_pkg::state_t follow;

  logic [3:0]  pos;
  logic [6:0]  round;
  logic [63:0] bit_length;
  logic [31:0] hash [5];
  logic [31:0] w [16];
  logic [31:0] a, b, c, d, e;

  logic        push;
  logic [31:0] push_word;
  logic        wrap;
  logic        load_out;
  logic [31:0] sched_word;
  logic [31:0] round_sum;

  // per-state control: which word enters the window, queue pop, output load
  always_comb begin
    push      = 1'b0;
    push_word = '0;
    pop_ready = 1'b0;
    load_out  = 1'b0;
    case (state)
      sha1d_pkg::ST_IDLE: begin
        pop_ready = 1'b1;
        push      = pop_valid;
        push_word = pop_data.word;
      end
      sha1d_pkg::ST_MARK: begin
        push      = 1'b1;
        push_word = sha1d_pkg::PAD_WORD;
      end
      sha1d_pkg::ST_FILL: begin
        push      = 1'b1;
        push_word = (pos == sha1d_pkg::LEN_SLOT) ? bit_length[63:32] : '0;
      end
      sha1d_pkg::ST_LEN_LO: begin
        push      = 1'b1;
        push_word = bit_length[31:0];
      end
      sha1d_pkg::ST_DONE: begin
        load_out = !out_valid || out_ready;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  assign wrap = push && (pos == sha1d_pkg::LAST_SLOT);

  // next state; a full block detours through compression and comes back
  always_comb begin
    follow      = state;
    state_next  = state;
    resume_next = resume;
    case (state)
      sha1d_pkg::ST_IDLE: begin
        if (pop_valid) begin
          if (!pop_data.last) begin
            follow = sha1d_pkg::ST_IDLE;
          end else if (pop_data.need_mark) begin
            follow = sha1d_pkg::ST_MARK;
          end else begin
            follow = sha1d_pkg::ST_FILL;
          end
        end
      end
      sha1d_pkg::ST_MARK: begin
        follow = sha1d_pkg::ST_FILL;
      end
      sha1d_pkg::ST_FILL: begin
        follow = (pos == sha1d_pkg::LEN_SLOT) ? sha1d_pkg::ST_LEN_LO : sha1d_pkg::ST_FILL;
      end
      sha1d_pkg::ST_LEN_LO: begin
        follow = sha1d_pkg::ST_DONE;
      end
      default: begin
        follow = state;
      end
    endcase

    case (state)
      sha1d_pkg::ST_COMPRESS: begin
        if (round == sha1d_pkg::LAST_ROUND) begin
          state_next = sha1d_pkg::ST_UPDATE;
        end
      end
      sha1d_pkg::ST_UPDATE: begin
        state_next = resume;
      end
      sha1d_pkg::ST_DONE: begin
        if (load_out) begin
          state_next = sha1d_pkg::ST_IDLE;
        end
      end
      default: begin
        if (wrap) begin
          state_next  = sha1d_pkg::ST_COMPRESS;
          resume_next = follow;
        end else begin
          state_next = follow;
        end
      end
    endcase
  end

  // schedule expansion and round adder
  assign sched_word = {w[13][30:0] ^ w[8][30:0] ^ w[2][30:0] ^ w[0][30:0],
                       w[13][31] ^ w[8][31] ^ w[2][31] ^ w[0][31]};
  assign round_sum  = {a[26:0], a[31:27]} + sha1d_pkg::round_f(round, b, c, d) + e
                      + sha1d_pkg::round_k(round) + w[0];

  // control state, hash and length
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sha1d_pkg::ST_IDLE;
      resume     <= sha1d_pkg::ST_IDLE;
      pos        <= '0;
      round      <= '0;
      bit_length <= '0;
      out_valid  <= 1'b0;
      hash[0]    <= sha1d_pkg::H0_INIT;
      hash[1]    <= sha1d_pkg::H1_INIT;
      hash[2]    <= sha1d_pkg::H2_INIT;
      hash[3]    <= sha1d_pkg::H3_INIT;
      hash[4]    <= sha1d_pkg::H4_INIT;
    end else begin
      state  <= state_next;
      resume <= resume_next;
      if (push) begin
        pos <= pos + 1'b1;
      end
      if (wrap) begin
        round <= '0;
      end else if (state == sha1d_pkg::ST_COMPRESS) begin
        round <= round + 1'b1;
      end
      if (pop_valid && pop_ready) begin
        bit_length <= bit_length + {58'd0, pop_data.add_bits};
      end
      if (state == sha1d_pkg::ST_UPDATE) begin
        hash[0] <= hash[0] + a;
        hash[1] <= hash[1] + b;
        hash[2] <= hash[2] + c;
        hash[3] <= hash[3] + d;
        hash[4] <= hash[4] + e;
      end
      // digest leaves; start the next message from the initial hash
      if (load_out) begin
        out_valid  <= 1'b1;
        bit_length <= '0;
        hash[0]    <= sha1d_pkg::H0_INIT;
        hash[1]    <= sha1d_pkg::H1_INIT;
        hash[2]    <= sha1d_pkg::H2_INIT;
        hash[3]    <= sha1d_pkg::H3_INIT;
        hash[4]    <= sha1d_pkg::H4_INIT;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // message window, working variables and output register
  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= push_word;
    end else if (state == sha1d_pkg::ST_COMPRESS) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= sched_word;
    end
    if (wrap) begin
      a <= hash[0];
      b <= hash[1];
      c <= hash[2];
      d <= hash[3];
      e <= hash[4];
    end else if (state == sha1d_pkg::ST_COMPRESS) begin
      a <= round_sum;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
    if (load_out) begin
      out_data.digest_0 <= hash[0];
      out_data.digest_1 <= hash[1];
      out_data.digest_2 <= hash[2];
      out_data.digest_3 <= hash[3];
      out_data.digest_4 <= hash[4];
    end
  end

  // sequencer checks
  `SHA1D_ASSERT_IMPL(a_round_range, state == sha1d_pkg::ST_COMPRESS, round <= sha1d_pkg::LAST_ROUND, "round index past last round")
  `SHA1D_ASSERT_NEXT(a_round_end, (state == sha1d_pkg::ST_COMPRESS) && (round == sha1d_pkg::LAST_ROUND), state == sha1d_pkg::ST_UPDATE, "compression did not end with hash update")
  `SHA1D_ASSERT_IMPL(a_len_slot, state == sha1d_pkg::ST_LEN_LO, pos == sha1d_pkg::LAST_SLOT, "low length word not in last slot")
  `SHA1D_ASSERT_IMPL(a_block_aligned, (state == sha1d_pkg::ST_UPDATE) || (state == sha1d_pkg::ST_DONE) || (state == sha1d_pkg::ST_COMPRESS), pos == 4'd0, "block not aligned at compression")

endmodule

/* rtl/sha1_digest_top.sv */
// sha1 digest top level: front classifier, word queue, compression back end
//
// Input channel in_valid/in_ready/in_data carries one big-endian message word
// per transfer, with byte_count and last_word. Output channel
// out_valid/out_ready/out_data carries the five digest words, one transfer
// per message, produced only by a last word.
// Words enter a QUEUE_DEPTH-entry queue and the back end takes one per cycle
// into the 16-word window while it is idle; each full block then keeps it from
// taking words while the single round unit compresses and updates the hash.
// After the last word the back end writes padding and length one word per
// cycle, pausing while a block compresses, and compresses one or two more
// blocks.
// The digest sits in an output register; while out_ready is low it holds,
// the back end waits in its done state and the queue keeps taking words
// until it is full. The next message may start right behind a last word.
// Synchronous reset rst clears the queue, length and position, loads the
// initial hash and drops out_valid; no clearing pass is needed.
module sha1_digest_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sha1d_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output sha1d_pkg::out_t  out_data
);

  sha1d_pkg::entry_t front_entry;
  sha1d_pkg::entry_t queue_entry;
  logic              queue_valid;
  logic              queue_ready;

  // classify incoming words
  sha1d_front u_front (
    .item  (in_data),
    .entry (front_entry)
  );

  // decoupling queue
  sha1d_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (front_entry),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_data   (queue_entry)
  );

  // padding, compression and digest register
  sha1d_core u_core (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (queue_valid),
    .pop_ready (queue_ready),
    .pop_data  (queue_entry),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* sim/tb_sha1_digest_top.sv */
// self-checking testbench for sha1_digest_top: streams messages and checks every digest
`timescale 1ns / 100ps

module tb_sha1_digest_top;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 300;
  localparam int HOLD_CYCLES    = 800;
  localparam int PHASE_WORDS    = 190;
  localparam int PRINT_LIMIT    = 40;

  logic            clk       = 1'b0;
  logic            rst       = 1'b1;
  logic            in_valid  = 1'b0;
  logic            out_ready = 1'b0;
  sha1d_pkg::in_t  in_data   = '0;
  logic            in_ready;
  logic            out_valid;
  sha1d_pkg::out_t out_data;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int words_sent     = 0;
  int quiet_cycles   = 0;

  // running sha-1 of the message in flight plus the digests still owed by the block
  class digest_scoreboard;
    logic [31:0]     hash [5];
    logic [31:0]     msg_block [16];
    int unsigned     slot;
    logic [63:0]     msg_bits;
    sha1d_pkg::out_t digest_q [$];
    int unsigned     mismatches;
    int unsigned     digests_checked;
    int unsigned     messages_seen;

    function new();
      mismatches      = 0;
      digests_checked = 0;
      messages_seen   = 0;
      start_message();
    endfunction

    function void start_message();
      hash[0]  = sha1d_pkg::H0_INIT;
      hash[1]  = sha1d_pkg::H1_INIT;
      hash[2]  = sha1d_pkg::H2_INIT;
      hash[3]  = sha1d_pkg::H3_INIT;
      hash[4]  = sha1d_pkg::H4_INIT;
      slot     = 0;
      msg_bits = '0;
    endfunction

    function logic [31:0] rotl(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
    endfunction

    // 80 rounds over the 16-word block into the running hash
    function void compress();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, k, wt, t_sum;
      for (int i = 0; i < 16; i++) w[i] = msg_block[i];
      a = hash[0];
      b = hash[1];
      c = hash[2];
      d = hash[3];
      e = hash[4];
      for (int t = 0; t < 80; t++) begin
        if (t < 16) begin
          wt = w[t];
        end else begin
          wt = rotl(w[(t - 3) % 16] ^ w[(t - 8) % 16] ^ w[(t - 14) % 16] ^ w[t % 16], 1);
          w[t % 16] = wt;
        end
        if (t < 20) begin
          f = (b & c) | (~b & d);
          k = sha1d_pkg::K0;
        end else if (t < 40) begin
          f = b ^ c ^ d;
          k = sha1d_pkg::K1;
        end else if (t < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = sha1d_pkg::K2;
        end else begin
          f = b ^ c ^ d;
          k = sha1d_pkg::K3;
        end
        t_sum = rotl(a, 5) + f + e + k + wt;
        e = d;
        d = c;
        c = rotl(b, 30);
        b = a;
        a = t_sum;
      end
      hash[0] += a;
      hash[1] += b;
      hash[2] += c;
      hash[3] += d;
      hash[4] += e;
    endfunction

    function void append(input logic [31:0] word);
      msg_block[slot] = word;
      slot = (slot + 1) % 16;
      if (slot == 0) compress();
    endfunction

    // one accepted input transfer; a last word closes the message and owes a digest
    function void note_word(input sha1d_pkg::in_t item);
      logic [2:0]      cnt;
      logic [31:0]     mask;
      sha1d_pkg::out_t digest;
      cnt = item.byte_count;
      if (!item.last_word || cnt > 3'd4) cnt = 3'd4;
      if (!item.last_word) begin
        msg_bits += 64'd32;
        append(item.message_word);
        return;
      end
      msg_bits += 64'(cnt) * 64'd8;
      if (cnt == 3'd4) begin
        append(item.message_word);
        append(sha1d_pkg::PAD_WORD);
      end else begin
        // keep the top cnt bytes, pad byte right behind them
        mask = ~(32'hffff_ffff >> (8 * cnt));
        append((item.message_word & mask) | (sha1d_pkg::PAD_WORD >> (8 * cnt)));
      end
      while (slot != int'(sha1d_pkg::LEN_SLOT)) append(32'h0);
      append(msg_bits[63:32]);
      append(msg_bits[31:0]);
      digest = {hash[0], hash[1], hash[2], hash[3], hash[4]};
      digest_q.insert(digest_q.size(), digest);
      messages_seen++;
      start_message();
    endfunction

    function int pending();
      return digest_q.size();
    endfunction

    task report_mismatch(input string msg);
      if (mismatches < PRINT_LIMIT) $display("%0t mismatch: %s", $time, msg);
      mismatches++;
    endtask

    // one accepted output transfer against the oldest owed digest
    task check_digest(input sha1d_pkg::out_t got);
      sha1d_pkg::out_t want;
      logic [31:0]     got_w, want_w;
      if (digest_q.size() == 0) begin
        report_mismatch($sformatf("digest %h with no message closed", got));
        return;
      end
      want = digest_q.pop_front();
      digests_checked++;
      for (int i = 0; i < 5; i++) begin
        got_w  = got[32 * (4 - i) +: 32];
        want_w = want[32 * (4 - i) +: 32];
        if (got_w !== want_w)
          report_mismatch($sformatf("digest_%0d got %h want %h", i, got_w, want_w));
      end
    endtask
  endclass

  digest_scoreboard digests = new();

  sha1_digest_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // receiver: long hold-off when asked, else random stalls
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // transfer monitor, scoreboard hookup and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) digests.note_word(in_data);
      if (out_valid && out_ready) digests.check_digest(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: %0d cycles without a transfer, %0d digests owed",
                 quiet_cycles, digests.pending());
        $display("** sha1_digest_top: FAILED **");
        $finish;
      end
    end
  end

  function automatic sha1d_pkg::in_t make_word(input logic [31:0] w, input logic [2:0] cnt,
                                               input logic last);
    sha1d_pkg::in_t item;
    item.message_word = w;
    item.byte_count   = cnt;
    item.last_word    = last;
    return item;
  endfunction

  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    case ($urandom_range(9))
      0:       w = 32'h0000_0000;
      1:       w = 32'hffff_ffff;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  task automatic send_word(input sha1d_pkg::in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  // whole message: body words with junk counts, then a last word with any count
  task automatic send_message(input int body_words);
    for (int i = 0; i < body_words; i++)
      send_word(make_word(rand_word(), 3'($urandom_range(7)), 1'b0));
    send_word(make_word(rand_word(), 3'($urandom_range(7)), 1'b1));
  endtask

  task automatic random_message();
    if ($urandom_range(9) == 0) send_message($urandom_range(21, 45));
    else send_message($urandom_range(0, 20));
  endtask

  // sender stops and waits until every owed digest has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (digests.pending() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int n_words);
    int target;
    target         = words_sent + n_words;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    while (words_sent < target) random_message();
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: empty, short and full last words, counts past four, ignored counts
    send_word(make_word(32'h0000_0000, 3'd0, 1'b1));
    send_word(make_word(32'h6162_6300, 3'd3, 1'b1));
    send_word(make_word(32'hffff_ffff, 3'd4, 1'b1));
    send_word(make_word(32'h8000_0000, 3'd1, 1'b1));
    send_word(make_word(32'h0000_0000, 3'd0, 1'b0));
    send_word(make_word(32'hffff_ffff, 3'd7, 1'b1));
    send_word(make_word(32'h1234_5678, 3'd5, 1'b1));
    send_word(make_word(32'hdead_beef, 3'd6, 1'b1));
    // short last word landing right before the length slot
    for (int i = 0; i < 13; i++) send_word(make_word($urandom, 3'(i), 1'b0));
    send_word(make_word($urandom, 3'd2, 1'b1));
    drain();

    run_phase(0, 0, PHASE_WORDS);

    // receiver holds off while short messages keep coming, queue fills up
    hold_left = HOLD_CYCLES;
    for (int i = 0; i < 25; i++) send_message($urandom_range(0, 2));
    drain();

    run_phase(48, 0, PHASE_WORDS);
    run_phase(0, 48, PHASE_WORDS);
    run_phase(7, 7, PHASE_WORDS);

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("run covered %0d words in %0d messages, %0d digests checked",
             words_sent, digests.messages_seen, digests.digests_checked);
    $display("idle mixes on both sides plus a long output hold-off, %0d mismatches",
             digests.mismatches);
    if (digests.mismatches == 0 && digests.pending() == 0) begin
      $display("** sha1_digest_top: PASSED **");
    end else begin
      $display("** sha1_digest_top: FAILED **");
    end
    $finish;
  end

endmodule

/* sha1_digest_top.f */
+incdir+rtl
rtl/sha1d_pkg.sv
rtl/sha1d_front.sv
rtl/sha1d_fifo.sv
rtl/sha1d_core.sv
rtl/sha1_digest_top.sv
sim/tb_sha1_digest_top.sv
